// ===== hw/rtl/psb_pkg.sv =====
// Shared types and constants for the positional sequence buffer.
package psb_pkg;

    // Fixed field widths of the request and result beats
    localparam int unsigned REQ_W  = 3;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned POS_W  = 6;
    localparam int unsigned STAT_W = 2;

    // Cell index width covers the largest supported capacity (64)
    localparam int unsigned IDX_W = 6;
    // Compare width holds a count up to the capacity plus one
    localparam int unsigned CMP_W = IDX_W + 1;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_INS_HEAD = 3'd0,
        REQ_INS_TAIL = 3'd1,
        REQ_INS_POS  = 3'd2,
        REQ_DEL_HEAD = 3'd3,
        REQ_DEL_TAIL = 3'd4,
        REQ_DEL_POS  = 3'd5,
        REQ_DISPLAY  = 3'd6
    } t_req_code;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // Controller states
    typedef enum logic {
        S_EDIT    = 1'b0,
        S_DISPLAY = 1'b1
    } t_state;

    // Action broadcast to every cell in the chain
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] idx;   // slot being inserted or removed
        logic [IDX_W-1:0] tail;  // last occupied slot, for rotation
    } t_cell_ctl;

endpackage

// ===== hw/rtl/psb_if.sv =====
// Request and result channel interfaces for the positional sequence buffer.
interface psb_req_if;
    logic                             valid;
    logic                             ready;
    logic [psb_pkg::REQ_W-1:0]        req_type;
    logic signed [psb_pkg::WORD_W-1:0] value;
    logic [psb_pkg::POS_W-1:0]        position;

    modport source (output valid, output req_type, output value, output position,
                    input ready);
    modport sink   (input valid, input req_type, input value, input position,
                    output ready);
endinterface

interface psb_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [psb_pkg::STAT_W-1:0]       status;
    logic                             has_value;
    logic signed [psb_pkg::WORD_W-1:0] data_out;
    logic                             last;

    modport source (output valid, output status, output has_value, output data_out,
                    output last, input ready);
    modport sink   (input valid, input status, input has_value, input data_out,
                    input last, output ready);
endinterface

// ===== hw/rtl/positional_sequence_buffer_unit.sv =====
// Top level of the positional sequence buffer: controller, cell chain, result register.
//
// Keeps an ordered sequence of up to CAPACITY signed words in a chain of cells.
// Request beats on i_req carry req_type, value and position; result beats on
// o_rsp carry status, has_value, data_out and last. A beat moves when valid
// and ready are both high at a rising edge of i_clk.
// On an insert or delete, every cell from the edited slot upward shifts at
// once, and the single result (last set) sits in the output register the
// cycle after the request beat. While the receiver holds ready high, a new
// request is taken in the following cycle, so edits sustain one request per
// cycle. Display first enters the display state, then gives one result per
// cycle while ready stays high, as the chain rotates by one slot, head first,
// last set on the final word; after count rotations the chain is back in its
// original order. Display of an empty sequence gives one result with status
// empty. Request code 7 is taken and dropped with no result.
// The output register frees when its beat is taken; while a result waits with
// ready low, the result and the chain hold and no request is taken.
// Reset (i_rst_n low at an edge) empties the sequence and the output
// register; stored words are not cleared.
module positional_sequence_buffer_unit #(
    parameter int unsigned CAPACITY   = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    psb_req_if.sink        i_req,
    psb_rsp_if.source      o_rsp
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned EXT_W = (DATA_WIDTH > psb_pkg::WORD_W) ? DATA_WIDTH
                                                                   : psb_pkg::WORD_W;

    // Control registers
    psb_pkg::t_state  r_state,  n_state;
    logic [CNT_W-1:0] r_count,  n_count;
    logic [CNT_W-1:0] r_left,   n_left;
    logic             r_out_valid, n_out_valid;

    // Result payload registers
    psb_pkg::t_status            r_status,    n_status;
    logic                        r_has_value, n_has_value;
    logic [psb_pkg::WORD_W-1:0]  r_data,      n_data;
    logic                        r_last,      n_last;

    logic                  w_can_load;
    logic                  w_accept;
    logic                  w_load;
    psb_pkg::t_cell_ctl    w_ctl;
    logic [DATA_WIDTH-1:0] w_word_in;
    logic [EXT_W-1:0]      w_value_ext;
    logic [EXT_W-1:0]      w_head_ext;
    logic [EXT_W-1:0]      w_pick_ext;
    logic [DATA_WIDTH-1:0] w_pick;
    logic                  w_full;
    logic [psb_pkg::CMP_W-1:0] w_count_x;
    logic [psb_pkg::CMP_W-1:0] w_pos_x;
    logic [psb_pkg::CMP_W-1:0] w_pos_m1;
    logic [psb_pkg::CMP_W-1:0] w_count_m1;

    logic [DATA_WIDTH-1:0] w_cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] w_cell_pick [CAPACITY];

    // Handshake
    assign w_can_load  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == psb_pkg::S_EDIT) && w_can_load;
    assign w_accept    = i_req.valid && i_req.ready;

    // Fit the incoming word to the stored width
    assign w_value_ext = EXT_W'($signed(i_req.value));
    assign w_word_in   = w_value_ext[DATA_WIDTH-1:0];

    // Counts and positions in a common width
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_count_x  = psb_pkg::CMP_W'(r_count);
    assign w_pos_x    = psb_pkg::CMP_W'(i_req.position);
    assign w_pos_m1   = w_pos_x - psb_pkg::CMP_W'(1);
    assign w_count_m1 = w_count_x - psb_pkg::CMP_W'(1);

    // Cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        psb_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_new_word (w_word_in),
            .i_lower    ((g == 0) ? w_word_in : w_cell_data[(g == 0) ? 0 : g - 1]),
            .i_upper    (w_cell_data[(g == CAPACITY - 1) ? g : g + 1]),
            .i_head     (w_cell_data[0]),
            .o_data     (w_cell_data[g]),
            .o_pick     (w_cell_pick[g])
        );
    end

    // Merge the addressed cell's word
    always_comb begin
        w_pick = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_pick = w_pick | w_cell_pick[k];
        end
    end

    assign w_pick_ext = EXT_W'($signed(w_pick));
    assign w_head_ext = EXT_W'($signed(w_cell_data[0]));

    // Decode requests, step the display, build the next result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_status    = r_status;
        n_has_value = r_has_value;
        n_data      = r_data;
        n_last      = r_last;
        w_load      = 1'b0;
        w_ctl.op    = psb_pkg::CELL_HOLD;
        w_ctl.idx   = '0;
        w_ctl.tail  = w_count_m1[psb_pkg::IDX_W-1:0];

        if (r_state == psb_pkg::S_DISPLAY) begin
            if (w_can_load) begin
                w_load      = 1'b1;
                w_ctl.op    = psb_pkg::CELL_ROTATE;
                n_status    = psb_pkg::ST_OK;
                n_has_value = 1'b1;
                n_data      = w_head_ext[psb_pkg::WORD_W-1:0];
                n_last      = (r_left == CNT_W'(1));
                n_left      = r_left - CNT_W'(1);
                if (r_left == CNT_W'(1)) begin
                    n_state = psb_pkg::S_EDIT;
                end
            end
        end else if (w_accept) begin
            n_has_value = 1'b0;
            n_data      = '0;
            n_last      = 1'b1;
            n_status    = psb_pkg::ST_OK;
            unique case (i_req.req_type)
                psb_pkg::REQ_INS_HEAD, psb_pkg::REQ_INS_TAIL: begin
                    w_load = 1'b1;
                    if (w_full) begin
                        n_status = psb_pkg::ST_FULL;
                    end else begin
                        w_ctl.op  = psb_pkg::CELL_INSERT;
                        w_ctl.idx = (i_req.req_type == psb_pkg::REQ_INS_HEAD)
                                    ? '0 : w_count_x[psb_pkg::IDX_W-1:0];
                        n_count   = r_count + CNT_W'(1);
                    end
                end
                psb_pkg::REQ_INS_POS: begin
                    w_load = 1'b1;
                    if (w_pos_x == '0 || w_pos_x > w_count_x + psb_pkg::CMP_W'(1)) begin
                        n_status = psb_pkg::ST_BADPOS;
                    end else if (w_full) begin
                        n_status = psb_pkg::ST_FULL;
                    end else begin
                        w_ctl.op  = psb_pkg::CELL_INSERT;
                        w_ctl.idx = w_pos_m1[psb_pkg::IDX_W-1:0];
                        n_count   = r_count + CNT_W'(1);
                    end
                end
                psb_pkg::REQ_DEL_HEAD, psb_pkg::REQ_DEL_TAIL, psb_pkg::REQ_DEL_POS: begin
                    w_load = 1'b1;
                    if (r_count == '0) begin
                        n_status = psb_pkg::ST_EMPTY;
                    end else if (i_req.req_type == psb_pkg::REQ_DEL_POS
                                 && (w_pos_x == '0 || w_pos_x > w_count_x)) begin
                        n_status = psb_pkg::ST_BADPOS;
                    end else begin
                        w_ctl.op = psb_pkg::CELL_REMOVE;
                        if (i_req.req_type == psb_pkg::REQ_DEL_HEAD) begin
                            w_ctl.idx = '0;
                        end else if (i_req.req_type == psb_pkg::REQ_DEL_TAIL) begin
                            w_ctl.idx = w_count_m1[psb_pkg::IDX_W-1:0];
                        end else begin
                            w_ctl.idx = w_pos_m1[psb_pkg::IDX_W-1:0];
                        end
                        n_has_value = 1'b1;
                        n_data      = w_pick_ext[psb_pkg::WORD_W-1:0];
                        n_count     = r_count - CNT_W'(1);
                    end
                end
                psb_pkg::REQ_DISPLAY: begin
                    if (r_count == '0) begin
                        w_load   = 1'b1;
                        n_status = psb_pkg::ST_EMPTY;
                    end else begin
                        n_state = psb_pkg::S_DISPLAY;
                        n_left  = r_count;
                    end
                end
                default: begin
                    // drop unknown request codes
                    w_load = 1'b0;
                end
            endcase
        end

        // Output register valid: load a beat, or free it once taken
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psb_pkg::S_EDIT;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status    <= n_status;
            r_has_value <= n_has_value;
            r_data      <= n_data;
            r_last      <= n_last;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_status;
    assign o_rsp.has_value = r_has_value;
    assign o_rsp.data_out  = r_data;
    assign o_rsp.last      = r_last;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count beyond capacity");

    a_no_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.has_value |-> o_rsp.data_out == '0)
        else $error("result without value carries nonzero data");

    a_display_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == psb_pkg::S_DISPLAY |-> r_left != '0 && r_left <= r_count)
        else $error("display count out of range");

    a_full_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_full && (i_req.req_type == psb_pkg::REQ_INS_HEAD
                               || i_req.req_type == psb_pkg::REQ_INS_TAIL)
        |=> o_rsp.valid && o_rsp.status == psb_pkg::ST_FULL && $stable(r_count))
        else $error("insert into full sequence not reported");

endmodule

// ===== hw/rtl/psb_cell.sv =====
// One storage cell of the sequence chain: holds a word, trades with its neighbors.
module psb_cell #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned CELL_IDX   = 0
) (
    input  logic                    i_clk,
    input  psb_pkg::t_cell_ctl      i_ctl,
    input  logic [DATA_WIDTH-1:0]   i_new_word,
    input  logic [DATA_WIDTH-1:0]   i_lower,
    input  logic [DATA_WIDTH-1:0]   i_upper,
    input  logic [DATA_WIDTH-1:0]   i_head,
    output logic [DATA_WIDTH-1:0]   o_data,
    output logic [DATA_WIDTH-1:0]   o_pick
);

    localparam logic [psb_pkg::IDX_W-1:0] MY_IDX = psb_pkg::IDX_W'(CELL_IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // Pick the next word from the broadcast action and this cell's slot
    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            psb_pkg::CELL_INSERT: begin
                if (MY_IDX == i_ctl.idx) begin
                    n_data = i_new_word;
                end else if (MY_IDX > i_ctl.idx) begin
                    n_data = i_lower;
                end
            end
            psb_pkg::CELL_REMOVE: begin
                if (MY_IDX >= i_ctl.idx) begin
                    n_data = i_upper;
                end
            end
            psb_pkg::CELL_ROTATE: begin
                if (MY_IDX == i_ctl.tail) begin
                    n_data = i_head;
                end else if (MY_IDX < i_ctl.tail) begin
                    n_data = i_upper;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // Offer the word when this slot is the one addressed
    assign o_pick = (MY_IDX == i_ctl.idx) ? r_data : '0;

endmodule
